// ===== sv/ffba_pkg.sv =====
// Package for the first-fit block allocator.
// Holds payload structs, table entry layout, operation/status/register codes
// and reset constants. Depends on nothing.
package ffba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 64;

   localparam logic [1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [1:0] FUNC_CALLOC  = 2'd1;
   localparam logic [1:0] FUNC_FREE    = 2'd2;
   localparam logic [1:0] FUNC_REALLOC = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SIZE  = 2'd1;
   localparam logic [1:0] ST_SPACE = 2'd2;
   localparam logic [1:0] ST_PTR   = 2'd3;

   localparam logic [1:0] REG_HEAP_BASE   = 2'd0;
   localparam logic [1:0] REG_HEAP_END    = 2'd1;
   localparam logic [1:0] REG_MAX_REQUEST = 2'd2;
   localparam logic [1:0] REG_METADATA    = 2'd3;

   localparam logic [31:0] HEAP_BASE_RESET   = 32'd0;
   localparam logic [31:0] HEAP_END_RESET    = 32'hFFFF_FFFF;
   localparam logic [26:0] MAX_REQUEST_RESET = 27'd100000000;
   localparam logic [7:0]  METADATA_RESET    = 8'd40;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] size_bytes;
      logic [31:0] elem_count;
      logic [31:0] user_pointer;
   } req_type;

   typedef struct packed {
      logic [31:0] result_pointer;
      logic [1:0]  status;
      logic [6:0]  free_blocks;
      logic [31:0] free_byte_sum;
      logic [6:0]  allocated_blocks;
      logic [31:0] used_byte_sum;
      logic [13:0] header_bytes;
   } rsp_type;

   typedef struct packed {
      logic [26:0] size;
      logic        free;
      logic [31:0] addr;
   } entry_type;

endpackage

// ===== sv/ffba_table.sv =====
// Block table memory: one write port, one read port, registered read data.
// Depends on ffba_pkg for the entry layout.
module ffba_table #(
   parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEFAULT,
   parameter int IW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  ffba_pkg::entry_type wr_data,
   input  logic [IW-1:0]       rd_addr,
   output ffba_pkg::entry_type rd_data
);

   ffba_pkg::entry_type mem [DEPTH];
   ffba_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/first_fit_block_allocator.sv =====
// First-fit block allocator.
// Requests (alloc, calloc, free, realloc) arrive on the req_ valid/ready
// channel; one result item per request leaves on the rsp_ channel. The
// csr_ channel writes heap_base, heap_end, max_request and metadata_bytes;
// it is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. One request is worked on at a
// time. The scans walk the block table memory one entry per cycle through
// its single read port; a realloc that must move scans the table twice.
// Rejected sizes and free of null skip the scan and go from the check
// state straight to the response state.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result is held back until the receiver takes the old.
// Reset is synchronous: the table becomes empty, heap top returns to the
// reset heap base, totals clear and configuration takes its reset values.
// Table contents need no clearing since only entries below the count are read.
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffba_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffba_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_PSCAN = 3'd2;
   localparam logic [2:0] S_ASCAN = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  func_ff, func_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] elem_ff, elem_in;
   logic [31:0] uptr_ff, uptr_in;
   logic [63:0] prod_ff, prod_in;
   logic [26:0] eff_ff, eff_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic        pend_ff, pend_in;
   logic [IW-1:0] ridx_ff, ridx_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] resptr_ff, resptr_in;
   logic [CW-1:0] blk_cnt_ff, blk_cnt_in;
   logic [CW-1:0] free_cnt_ff, free_cnt_in;
   logic [31:0] heap_top_ff, heap_top_in;
   logic [31:0] free_sum_ff, free_sum_in;
   logic [31:0] used_bytes_ff, used_bytes_in;
   logic [31:0] heap_base_ff, heap_base_in;
   logic [31:0] heap_end_ff, heap_end_in;
   logic [26:0] max_req_ff, max_req_in;
   logic [7:0]  meta_ff, meta_in;
   logic        rsp_valid_ff, rsp_valid_in;
   ffba_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   ffba_pkg::entry_type mem_wdata;
   logic [IW-1:0]       mem_raddr;
   ffba_pkg::entry_type mem_rdata;

   logic        payload_hit, fit_hit, hit;
   logic [33:0] need;

   ffba_table #(.DEPTH(MAX_BLOCKS), .IW(IW)) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign payload_hit = (32'(mem_rdata.addr + 32'(meta_ff)) == uptr_ff);
   assign fit_hit     = mem_rdata.free && (mem_rdata.size >= eff_ff);
   assign hit         = pend_ff && ((state_ff == S_PSCAN) ? payload_hit : fit_hit);
   assign need        = 34'(heap_top_ff) + 34'(meta_ff) + 34'(eff_ff);

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      size_in       = size_ff;
      elem_in       = elem_ff;
      uptr_in       = uptr_ff;
      prod_in       = prod_ff;
      eff_in        = eff_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      ridx_in       = ridx_ff;
      status_in     = status_ff;
      resptr_in     = resptr_ff;
      blk_cnt_in    = blk_cnt_ff;
      free_cnt_in   = free_cnt_ff;
      heap_top_in   = heap_top_ff;
      free_sum_in   = free_sum_ff;
      used_bytes_in = used_bytes_ff;
      heap_base_in  = heap_base_ff;
      heap_end_in   = heap_end_ff;
      max_req_in    = max_req_ff;
      meta_in       = meta_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = ridx_ff;
      mem_wdata     = mem_rdata;
      mem_raddr     = idx_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in   = req_data.func;
               size_in   = req_data.size_bytes;
               elem_in   = req_data.elem_count;
               uptr_in   = req_data.user_pointer;
               prod_in   = 64'(req_data.size_bytes) * 64'(req_data.elem_count);
               status_in = ffba_pkg::ST_OK;
               resptr_in = 32'd0;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            idx_in  = '0;
            pend_in = 1'b0;
            eff_in  = size_ff[26:0];
            case (func_ff)
               ffba_pkg::FUNC_ALLOC: begin
                  if (size_ff == 32'd0 || size_ff > 32'(max_req_ff)) begin
                     status_in = ffba_pkg::ST_SIZE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ASCAN;
                  end
               end
               ffba_pkg::FUNC_CALLOC: begin
                  eff_in = prod_ff[26:0];
                  if (size_ff == 32'd0 || elem_ff == 32'd0 || prod_ff > 64'(max_req_ff)) begin
                     status_in = ffba_pkg::ST_SIZE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_ASCAN;
                  end
               end
               ffba_pkg::FUNC_FREE: begin
                  state_in = (uptr_ff == 32'd0) ? S_RESP : S_PSCAN;
               end
               default: begin
                  if (size_ff == 32'd0 || size_ff > 32'(max_req_ff)) begin
                     status_in = ffba_pkg::ST_SIZE;
                     state_in  = S_RESP;
                  end else if (uptr_ff == 32'd0) begin
                     state_in = S_ASCAN;
                  end else begin
                     state_in = S_PSCAN;
                  end
               end
            endcase
         end
         S_PSCAN, S_ASCAN: begin
            if (hit) begin
               pend_in = 1'b0;
               if (state_ff == S_ASCAN) begin
                  mem_we         = 1'b1;
                  mem_wdata.free = 1'b0;
                  free_cnt_in    = free_cnt_ff - CW'(1);
                  free_sum_in    = 32'(free_sum_ff - 32'(mem_rdata.size));
                  resptr_in      = 32'(mem_rdata.addr + 32'(meta_ff));
                  state_in       = S_RESP;
               end else if (func_ff == ffba_pkg::FUNC_REALLOC &&
                            mem_rdata.size >= eff_ff) begin
                  resptr_in = uptr_ff;
                  state_in  = S_RESP;
               end else begin
                  // Mark the matched block free; a realloc then searches anew.
                  if (!mem_rdata.free) begin
                     mem_we         = 1'b1;
                     mem_wdata.free = 1'b1;
                     free_cnt_in    = free_cnt_ff + CW'(1);
                     free_sum_in    = 32'(free_sum_ff + 32'(mem_rdata.size));
                  end
                  if (func_ff == ffba_pkg::FUNC_REALLOC) begin
                     idx_in   = '0;
                     state_in = S_ASCAN;
                  end else begin
                     state_in = S_RESP;
                  end
               end
            end else if (idx_ff < blk_cnt_ff) begin
               pend_in = 1'b1;
               ridx_in = idx_ff[IW-1:0];
               idx_in  = idx_ff + CW'(1);
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else if (state_ff == S_PSCAN) begin
               status_in = ffba_pkg::ST_PTR;
               state_in  = S_RESP;
            end else begin
               if (blk_cnt_ff >= CW'(MAX_BLOCKS) || need > 34'(heap_end_ff)) begin
                  status_in = ffba_pkg::ST_SPACE;
                  resptr_in = 32'd0;
               end else begin
                  mem_we         = 1'b1;
                  mem_waddr      = blk_cnt_ff[IW-1:0];
                  mem_wdata.size = eff_ff;
                  mem_wdata.free = 1'b0;
                  mem_wdata.addr = heap_top_ff;
                  blk_cnt_in     = blk_cnt_ff + CW'(1);
                  used_bytes_in  = 32'(used_bytes_ff + 32'(eff_ff));
                  heap_top_in    = need[31:0];
                  resptr_in      = 32'(heap_top_ff + 32'(meta_ff));
               end
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.result_pointer   = resptr_ff;
               rsp_data_in.status           = status_ff;
               rsp_data_in.free_blocks      = 7'(free_cnt_ff);
               rsp_data_in.free_byte_sum    = free_sum_ff;
               rsp_data_in.allocated_blocks = 7'(blk_cnt_ff);
               rsp_data_in.used_byte_sum    = used_bytes_ff;
               rsp_data_in.header_bytes     = 14'(blk_cnt_ff) * 14'(meta_ff);
               state_in                     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            ffba_pkg::REG_HEAP_BASE: begin
               heap_base_in = csr_data;
               if (blk_cnt_ff == '0) begin
                  heap_top_in = csr_data;
               end
            end
            ffba_pkg::REG_HEAP_END:    heap_end_in = csr_data;
            ffba_pkg::REG_MAX_REQUEST: max_req_in  = csr_data[26:0];
            ffba_pkg::REG_METADATA:    meta_in     = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_ff       <= 1'b0;
         blk_cnt_ff    <= '0;
         free_cnt_ff   <= '0;
         heap_top_ff   <= ffba_pkg::HEAP_BASE_RESET;
         free_sum_ff   <= 32'd0;
         used_bytes_ff <= 32'd0;
         heap_base_ff  <= ffba_pkg::HEAP_BASE_RESET;
         heap_end_ff   <= ffba_pkg::HEAP_END_RESET;
         max_req_ff    <= ffba_pkg::MAX_REQUEST_RESET;
         meta_ff       <= ffba_pkg::METADATA_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         blk_cnt_ff    <= blk_cnt_in;
         free_cnt_ff   <= free_cnt_in;
         heap_top_ff   <= heap_top_in;
         free_sum_ff   <= free_sum_in;
         used_bytes_ff <= used_bytes_in;
         heap_base_ff  <= heap_base_in;
         heap_end_ff   <= heap_end_in;
         max_req_ff    <= max_req_in;
         meta_ff       <= meta_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff     <= func_in;
      size_ff     <= size_in;
      elem_ff     <= elem_in;
      uptr_ff     <= uptr_in;
      prod_ff     <= prod_in;
      eff_ff      <= eff_in;
      idx_ff      <= idx_in;
      ridx_ff     <= ridx_in;
      status_ff   <= status_in;
      resptr_ff   <= resptr_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_free_le_count: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= blk_cnt_ff)
      else $error("free block count exceeds table count");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_RESP))
      else $error("result appeared outside the response state");

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK))
      else $error("accepted item did not enter the check state");

   a_write_in_table: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) <= blk_cnt_ff))
      else $error("table write beyond the block count");

endmodule
